[hw/rtl/qrm_pkg.sv]
// shared types and constants of the quaternion row rotation block
// word layouts for both channels and fixed-point constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qrm_pkg;

  // one input word: a matrix row in Q16.16 and a quaternion in Q1.14
  typedef struct packed {
    logic signed [31:0] row_c0;
    logic signed [31:0] row_c1;
    logic signed [31:0] row_c2;
    logic signed [31:0] row_c3;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } row_in_t;

  // one output word: the rotated row in Q16.16
  typedef struct packed {
    logic signed [31:0] out_c0;
    logic signed [31:0] out_c1;
    logic signed [31:0] out_c2;
    logic signed [31:0] out_c3;
  } row_out_t;

  localparam int QP_W   = 32;  // quaternion product, units of 2^-28
  localparam int ROT_W  = 33;  // rotation element, units of 2^-27
  localparam int PROD_W = 65;  // row element times rotation element
  localparam int SUM_W  = 67;  // sum of three products
  localparam int SHIFT  = 27;

  localparam logic signed [ROT_W-1:0] ROT_ONE   = ROT_W'(64'sd134217728);
  localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(64'sd67108864);

  function automatic logic signed [ROT_W-1:0] sx_rot(input logic signed [QP_W-1:0] v);
    sx_rot = {v[QP_W-1], v};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/qrm_ifs.sv]
// valid/ready channel interfaces of the quaternion row rotation block
// depends on qrm_pkg for the word types
`timescale 1ns / 1ps
`default_nettype none

interface qrm_in_if;
  logic             valid;
  logic             ready;
  qrm_pkg::row_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qrm_out_if;
  logic              valid;
  logic              ready;
  qrm_pkg::row_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/quaternion_rotate_matrix_row.sv]
// Rotates one 4x4 matrix row per word by the rotation matrix of a quaternion
// (the fourth column passes through unrotated). It takes one word per cycle
// unless the output stalls; registered stages hold the quaternion products,
// rotation elements, row-by-rotation multiplies, the 67-bit column sums and
// the round/saturate step; the rate is set by the 32x33 multipliers of the
// third stage, nine working in parallel. Each stage moves on when the next
// one is empty or moving, so a stall at the output holds the pipe without loss
// and bubbles are squeezed out. The quaternion is used as given, not normalized.
// depends on qrm_pkg and qrm_ifs
`timescale 1ns / 1ps
`default_nettype none

module quaternion_rotate_matrix_row (
  input  wire logic   clk,
  input  wire logic   rst,
  qrm_in_if.sink      row_in,
  qrm_out_if.source   row_out
);

  localparam int QP_W   = qrm_pkg::QP_W;
  localparam int ROT_W  = qrm_pkg::ROT_W;
  localparam int PROD_W = qrm_pkg::PROD_W;
  localparam int SUM_W  = qrm_pkg::SUM_W;
  localparam int SHIFT  = qrm_pkg::SHIFT;
  localparam int VW     = SUM_W - SHIFT;  // width after the shift

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 1: quaternion products
  logic signed [QP_W-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic signed [31:0]     row1 [3];
  logic signed [31:0]     c3_1;

  // stage 2: rotation elements, rot[k][j]
  logic signed [ROT_W-1:0] rot [3][3];
  logic signed [31:0]      row2 [3];
  logic signed [31:0]      c3_2;

  // stage 3: products, prod[j][k] = row[k] * rot[k][j]
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [31:0]       c3_3;

  // stage 4: rounded column sums
  logic signed [SUM_W-1:0] sum [3];
  logic signed [31:0]      c3_4;

  // stage 5: output register
  qrm_pkg::row_out_t out_word;
  logic signed [31:0] sat_next [3];

  assign rdy5 = !v5 || row_out.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign row_in.ready  = rdy1;
  assign row_out.valid = v5;
  assign row_out.data  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= row_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      xx      <= row_in.data.quat_x * row_in.data.quat_x;
      yy      <= row_in.data.quat_y * row_in.data.quat_y;
      zz      <= row_in.data.quat_z * row_in.data.quat_z;
      xy      <= row_in.data.quat_x * row_in.data.quat_y;
      xz      <= row_in.data.quat_x * row_in.data.quat_z;
      yz      <= row_in.data.quat_y * row_in.data.quat_z;
      xw      <= row_in.data.quat_x * row_in.data.quat_w;
      yw      <= row_in.data.quat_y * row_in.data.quat_w;
      zw      <= row_in.data.quat_z * row_in.data.quat_w;
      row1[0] <= row_in.data.row_c0;
      row1[1] <= row_in.data.row_c1;
      row1[2] <= row_in.data.row_c2;
      c3_1    <= row_in.data.row_c3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      rot[0][0] <= qrm_pkg::ROT_ONE - (qrm_pkg::sx_rot(yy) + qrm_pkg::sx_rot(zz));
      rot[0][1] <= qrm_pkg::sx_rot(xy) - qrm_pkg::sx_rot(zw);
      rot[0][2] <= qrm_pkg::sx_rot(xz) + qrm_pkg::sx_rot(yw);
      rot[1][0] <= qrm_pkg::sx_rot(xy) + qrm_pkg::sx_rot(zw);
      rot[1][1] <= qrm_pkg::ROT_ONE - (qrm_pkg::sx_rot(xx) + qrm_pkg::sx_rot(zz));
      rot[1][2] <= qrm_pkg::sx_rot(yz) - qrm_pkg::sx_rot(xw);
      rot[2][0] <= qrm_pkg::sx_rot(xz) - qrm_pkg::sx_rot(yw);
      rot[2][1] <= qrm_pkg::sx_rot(yz) + qrm_pkg::sx_rot(xw);
      rot[2][2] <= qrm_pkg::ROT_ONE - (qrm_pkg::sx_rot(xx) + qrm_pkg::sx_rot(yy));
      row2      <= row1;
      c3_2      <= c3_1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod[j][k] <= row2[k] * rot[k][j];
        end
      end
      c3_3 <= c3_2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int j = 0; j < 3; j++) begin
        sum[j] <= SUM_W'(prod[j][0]) + SUM_W'(prod[j][1]) + SUM_W'(prod[j][2])
                  + qrm_pkg::ROUND_ADD;
      end
      c3_4 <= c3_3;
    end
  end

  // arithmetic shift by slice, then clamp to the 32-bit range
  always_comb begin
    logic [VW-1:0] shifted;
    for (int j = 0; j < 3; j++) begin
      shifted = sum[j][SUM_W-1:SHIFT];
      if (shifted[VW-1:31] == '0 || shifted[VW-1:31] == '1) begin
        sat_next[j] = shifted[31:0];
      end else if (shifted[VW-1]) begin
        sat_next[j] = 32'sh8000_0000;
      end else begin
        sat_next[j] = 32'sh7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_word.out_c0 <= sat_next[0];
      out_word.out_c1 <= sat_next[1];
      out_word.out_c2 <= sat_next[2];
      out_word.out_c3 <= c3_4;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/qrm_checker.sv]
// port-level checks for the quaternion row rotation block, bound to the top
// depends only on the handshake signals of quaternion_rotate_matrix_row
`timescale 1ns / 1ps
`default_nettype none

module qrm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  logic       in_acc, out_acc;
  logic [2:0] inflight;
  logic [2:0] inflight_next;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_next = inflight;
    if (in_acc && !out_acc) inflight_next = inflight + 3'd1;
    else if (out_acc && !in_acc) inflight_next = inflight - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= inflight_next;
    end
  end

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // an open output lets the pipe take a word every cycle
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is open");

  // never more words inside than pipe stages
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd5)
    else $error("more words in flight than stages");

  // no word shows up that was never taken in
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    inflight == 3'd0 |-> !out_valid)
    else $error("output word with nothing in flight");

endmodule

bind quaternion_rotate_matrix_row qrm_checker u_qrm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (row_in.valid),
  .in_ready  (row_in.ready),
  .out_valid (row_out.valid),
  .out_ready (row_out.ready)
);

`default_nettype wire
